### design/dde_pkg.sv
// shared types, constants and the cosine table for the direct dft engine
// no dependencies
package dde_pkg;

  localparam int MAX_POINTS_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int TWID_W      = 16;
  localparam int TWID_ADDR_W = 6;
  localparam int SIN_OFS     = 48;
  localparam int FRAC_BITS   = 15;
  localparam int SHIFT_W     = 5;
  localparam int OUT_W       = 24;
  localparam int INDEX_W     = 6;
  localparam int LOG2_W      = 3;
  localparam int LOG2_RESET  = 6;
  localparam int OUT_DATA_W  = ((2 * OUT_W + INDEX_W + 7) / 8) * 8;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // cos(2*pi*m/64) in q1.15
  localparam logic signed [TWID_W-1:0] COS_TAB [64] = '{
     16'sd32767,  16'sd32610,  16'sd32138,  16'sd31357,
     16'sd30274,  16'sd28899,  16'sd27246,  16'sd25330,
     16'sd23170,  16'sd20788,  16'sd18205,  16'sd15447,
     16'sd12540,   16'sd9512,   16'sd6393,   16'sd3212,
         16'sd0,  -16'sd3212,  -16'sd6393,  -16'sd9512,
    -16'sd12540, -16'sd15447, -16'sd18205, -16'sd20788,
    -16'sd23170, -16'sd25330, -16'sd27246, -16'sd28899,
    -16'sd30274, -16'sd31357, -16'sd32138, -16'sd32610,
     16'sh8000,  -16'sd32610, -16'sd32138, -16'sd31357,
    -16'sd30274, -16'sd28899, -16'sd27246, -16'sd25330,
    -16'sd23170, -16'sd20788, -16'sd18205, -16'sd15447,
    -16'sd12540,  -16'sd9512,  -16'sd6393,  -16'sd3212,
         16'sd0,   16'sd3212,   16'sd6393,   16'sd9512,
     16'sd12540,  16'sd15447,  16'sd18205,  16'sd20788,
     16'sd23170,  16'sd25330,  16'sd27246,  16'sd28899,
     16'sd30274,  16'sd31357,  16'sd32138,  16'sd32610
  };

  typedef struct packed {
    logic               vld;
    logic               first;
    logic               last_n;
    logic               last_k;
    logic [INDEX_W-1:0] k;
  } dde_tag_t;

  typedef struct packed {
    logic              inv;
    logic [LOG2_W-1:0] log2n;
  } dde_mode_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_RUN,
    ST_DRAIN
  } dde_state_t;

  typedef enum logic {
    REG_INVERSE = 1'b0,
    REG_LOG2    = 1'b1
  } dde_reg_t;

endpackage

### design/dde_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module dde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/dde_ctrl.sv
// load counter and bin/sample sequencer: writes the store, then issues store reads
// depends on dde_pkg
module dde_ctrl #(
  parameter int MAX_POINTS = dde_pkg::MAX_POINTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  dde_pkg::dde_mode_t                cfg_mode,
  input  logic                              adv,
  input  logic                              drain_done,
  output logic                              wr_en,
  output logic [$clog2(MAX_POINTS)-1:0]     wr_addr,
  output logic [$clog2(MAX_POINTS)-1:0]     rd_addr,
  output dde_pkg::dde_tag_t                 tag0,
  output logic [dde_pkg::TWID_ADDR_W-1:0]   phase0,
  output dde_pkg::dde_mode_t                run_mode
);
  import dde_pkg::*;

  localparam int IDX_W   = $clog2(MAX_POINTS);
  localparam int CNT_W   = IDX_W + 1;
  localparam int LOG_MAX = $clog2(MAX_POINTS + 1) - 1;

  dde_state_t              state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [IDX_W-1:0]        n_r, n_nxt;
  logic [IDX_W-1:0]        k_r, k_nxt;
  logic [IDX_W-1:0]        nmax_r, nmax_nxt;
  logic [TWID_ADDR_W-1:0]  phase_r, phase_nxt;
  logic [TWID_ADDR_W-1:0]  kstep_r, kstep_nxt;
  logic [TWID_ADDR_W-1:0]  step_r, step_nxt;
  logic [TWID_ADDR_W-1:0]  phase0_r, phase0_nxt;
  logic [IDX_W-1:0]        rd_addr_r, rd_addr_nxt;
  dde_tag_t                tag0_r, tag0_nxt;
  dde_mode_t               mode_r, mode_nxt;

  logic [LOG2_W-1:0]       l_eff;
  logic [CNT_W-1:0]        n_pts;
  logic [CNT_W-1:0]        cnt_inc;
  logic                    accept;

  // effective length: clamp to 1..6, then to what the store holds
  always_comb begin
    l_eff = cfg_mode.log2n;
    if (l_eff == '0) begin
      l_eff = LOG2_W'(1);
    end else if (l_eff > LOG2_W'(TWID_ADDR_W)) begin
      l_eff = LOG2_W'(TWID_ADDR_W);
    end
    if (l_eff > LOG2_W'(LOG_MAX)) begin
      l_eff = LOG2_W'(LOG_MAX);
    end
  end

  assign n_pts    = CNT_W'(1) << l_eff;
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign in_ready = (state_r == ST_LOAD);
  assign accept   = in_valid && in_ready;
  assign wr_en    = accept;
  assign wr_addr  = cnt_r[IDX_W-1:0];

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    n_nxt       = n_r;
    k_nxt       = k_r;
    nmax_nxt    = nmax_r;
    phase_nxt   = phase_r;
    kstep_nxt   = kstep_r;
    step_nxt    = step_r;
    phase0_nxt  = phase0_r;
    rd_addr_nxt = rd_addr_r;
    tag0_nxt    = tag0_r;
    mode_nxt    = mode_r;
    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (cnt_inc >= n_pts) begin
            cnt_nxt        = '0;
            state_nxt      = ST_RUN;
            n_nxt          = '0;
            k_nxt          = '0;
            phase_nxt      = '0;
            kstep_nxt      = '0;
            step_nxt       = TWID_ADDR_W'(1) << (LOG2_W'(TWID_ADDR_W) - l_eff);
            nmax_nxt       = IDX_W'(n_pts - CNT_W'(1));
            mode_nxt.inv   = cfg_mode.inv;
            mode_nxt.log2n = l_eff;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      end
      ST_RUN: begin
        if (adv) begin
          tag0_nxt.vld    = 1'b1;
          tag0_nxt.first  = (n_r == '0);
          tag0_nxt.last_n = (n_r == nmax_r);
          tag0_nxt.last_k = (k_r == nmax_r);
          tag0_nxt.k      = INDEX_W'(k_r);
          rd_addr_nxt     = n_r;
          phase0_nxt      = phase_r;
          if (n_r == nmax_r) begin
            n_nxt     = '0;
            phase_nxt = '0;
            k_nxt     = k_r + IDX_W'(1);
            kstep_nxt = kstep_r + step_r;
            if (k_r == nmax_r) begin
              state_nxt = ST_DRAIN;
            end
          end else begin
            n_nxt     = n_r + IDX_W'(1);
            phase_nxt = phase_r + kstep_r;
          end
        end
      end
      ST_DRAIN: begin
        if (adv) begin
          tag0_nxt = '0;
        end
        if (drain_done) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      tag0_r  <= '0;
      mode_r  <= '{inv: 1'b0, log2n: LOG2_W'(LOG2_RESET)};
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      tag0_r  <= tag0_nxt;
      mode_r  <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    k_r       <= k_nxt;
    nmax_r    <= nmax_nxt;
    phase_r   <= phase_nxt;
    kstep_r   <= kstep_nxt;
    step_r    <= step_nxt;
    phase0_r  <= phase0_nxt;
    rd_addr_r <= rd_addr_nxt;
  end

  assign rd_addr  = rd_addr_r;
  assign tag0     = tag0_r;
  assign phase0   = phase0_r;
  assign run_mode = mode_r;

endmodule

### design/dde_mac.sv
// multiply-accumulate datapath: twiddle lookup, complex products, accumulation,
// rounding shift, saturation and the output register; depends on dde_pkg
module dde_mac #(
  parameter int MAX_POINTS  = dde_pkg::MAX_POINTS_DEF,
  parameter int SAMPLE_BITS = dde_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  dde_pkg::dde_tag_t                      tag0,
  input  logic [dde_pkg::TWID_ADDR_W-1:0]        phase0,
  input  logic [2*SAMPLE_BITS-1:0]               rdata,
  input  dde_pkg::dde_mode_t                     run_mode,
  input  logic                                   out_ready,
  output logic                                   adv,
  output logic                                   drain_done,
  output logic                                   out_valid,
  output logic signed [dde_pkg::OUT_W-1:0]       out_re,
  output logic signed [dde_pkg::OUT_W-1:0]       out_im,
  output logic [dde_pkg::INDEX_W-1:0]            out_index,
  output logic                                   out_last
);
  import dde_pkg::*;

  localparam int PW    = SAMPLE_BITS + TWID_W;
  localparam int TW    = PW + 1;
  localparam int ACC_W = TW + $clog2(MAX_POINTS);
  localparam int RW    = ACC_W + 1;
  localparam logic signed [RW-1:0] SAT_MAX = RW'(2 ** (OUT_W - 1) - 1);
  localparam logic signed [RW-1:0] SAT_MIN = -SAT_MAX - RW'(1);

  dde_tag_t                  tag1_r, tag2_r, tag3_r, tag4_r, tag5_r;
  dde_tag_t                  tag3_done;
  logic [TWID_ADDR_W-1:0]    phase1_r;
  logic signed [SAMPLE_BITS-1:0] a, b;
  logic signed [TWID_W-1:0]  c, s;
  logic signed [PW-1:0]      p_ac, p_bs, p_bc, p_as;
  logic signed [PW-1:0]      p_ac_r, p_bs_r, p_bc_r, p_as_r;
  logic signed [TW-1:0]      re_t_r, im_t_r;
  logic signed [ACC_W-1:0]   acc_re_r, acc_im_r;
  logic signed [RW-1:0]      rnd_re_r, rnd_im_r;
  logic [SHIFT_W-1:0]        sh, sh5_r;
  logic signed [RW-1:0]      bias;
  logic signed [RW-1:0]      shr_re, shr_im;
  logic signed [OUT_W-1:0]   sat_re, sat_im;
  logic                      out_valid_r;
  logic signed [OUT_W-1:0]   out_re_r, out_im_r;
  logic [INDEX_W-1:0]        out_index_r;
  logic                      out_last_r;

  assign adv        = !out_valid_r || out_ready;
  assign drain_done = adv && tag5_r.vld && tag5_r.last_k;

  assign a = $signed(rdata[SAMPLE_BITS-1:0]);
  assign b = $signed(rdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
  assign c = COS_TAB[phase1_r];
  assign s = COS_TAB[phase1_r + TWID_ADDR_W'(SIN_OFS)];

  assign p_ac = a * c;
  assign p_bs = b * s;
  assign p_bc = b * c;
  assign p_as = a * s;

  assign sh   = run_mode.inv ? SHIFT_W'(FRAC_BITS) + SHIFT_W'(run_mode.log2n)
                             : SHIFT_W'(FRAC_BITS);
  assign bias = RW'(1) <<< (sh - SHIFT_W'(1));

  assign shr_re = rnd_re_r >>> sh5_r;
  assign shr_im = rnd_im_r >>> sh5_r;

  // only the final term of a bin carries on past the accumulator
  always_comb begin
    tag3_done     = tag3_r;
    tag3_done.vld = tag3_r.vld && tag3_r.last_n;
  end

  always_comb begin
    if (shr_re > SAT_MAX) begin
      sat_re = SAT_MAX[OUT_W-1:0];
    end else if (shr_re < SAT_MIN) begin
      sat_re = SAT_MIN[OUT_W-1:0];
    end else begin
      sat_re = shr_re[OUT_W-1:0];
    end
    if (shr_im > SAT_MAX) begin
      sat_im = SAT_MAX[OUT_W-1:0];
    end else if (shr_im < SAT_MIN) begin
      sat_im = SAT_MIN[OUT_W-1:0];
    end else begin
      sat_im = shr_im[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r      <= '0;
      tag2_r      <= '0;
      tag3_r      <= '0;
      tag4_r      <= '0;
      tag5_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      tag1_r      <= tag0;
      tag2_r      <= tag1_r;
      tag3_r      <= tag2_r;
      tag4_r      <= tag3_done;
      tag5_r      <= tag4_r;
      out_valid_r <= tag5_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      phase1_r <= phase0;
      p_ac_r   <= p_ac;
      p_bs_r   <= p_bs;
      p_bc_r   <= p_bc;
      p_as_r   <= p_as;
      // forward uses exp(-i), inverse exp(+i)
      if (run_mode.inv) begin
        re_t_r <= TW'(p_ac_r) - TW'(p_bs_r);
        im_t_r <= TW'(p_bc_r) + TW'(p_as_r);
      end else begin
        re_t_r <= TW'(p_ac_r) + TW'(p_bs_r);
        im_t_r <= TW'(p_bc_r) - TW'(p_as_r);
      end
      if (tag3_r.vld) begin
        if (tag3_r.first) begin
          acc_re_r <= ACC_W'(re_t_r);
          acc_im_r <= ACC_W'(im_t_r);
        end else begin
          acc_re_r <= acc_re_r + ACC_W'(re_t_r);
          acc_im_r <= acc_im_r + ACC_W'(im_t_r);
        end
      end
      rnd_re_r <= RW'(acc_re_r) + bias;
      rnd_im_r <= RW'(acc_im_r) + bias;
      sh5_r    <= sh;
      if (tag5_r.vld) begin
        out_re_r    <= sat_re;
        out_im_r    <= sat_im;
        out_index_r <= tag5_r.k;
        out_last_r  <= tag5_r.last_k;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_re    = out_re_r;
  assign out_im    = out_im_r;
  assign out_index = out_index_r;
  assign out_last  = out_last_r;

endmodule

### design/direct_dft_engine.sv
// Direct DFT engine. Samples arrive one per transfer on the input stream and are written
// into a MAX_POINTS-entry store; the transfer that completes a block of N = 2^log2_points
// (clamped to 1..6 and to the store size) starts the transform, and the input stays
// stalled until the last result of the block has reached the output register. The
// store has one read port, so each result takes N store reads and N complex
// multiply-accumulates, one per cycle while the output side keeps up. Backpressure on
// the output freezes the whole datapath. Forward mode is unscaled; inverse mode
// scales by 1/N with round-half-up, and results saturate to 24 bits.
// Registers (at byte address 4*i): inverse_mode, log2_points; write them only while
// the block is idle. Depends on dde_pkg, dde_ram, dde_ctrl and dde_mac.
module direct_dft_engine #(
  parameter int MAX_POINTS  = dde_pkg::MAX_POINTS_DEF,
  parameter int SAMPLE_BITS = dde_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  // sample_re, sample_im
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]        in_tdata,
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  // out_re, out_im, out_index
  output logic [dde_pkg::OUT_DATA_W-1:0]            out_tdata,
  output logic                                      out_tlast,
  input  logic                                      psel,
  input  logic                                      penable,
  input  logic                                      pwrite,
  input  logic [dde_pkg::CFG_ADDR_W-1:0]            paddr,
  input  logic [dde_pkg::CFG_DATA_W-1:0]            pwdata,
  output logic [dde_pkg::CFG_DATA_W-1:0]            prdata,
  output logic                                      pready
);
  import dde_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);

  logic                     inv_r;
  logic [LOG2_W-1:0]        log2_r;
  dde_reg_t                 reg_sel;
  logic                     cfg_wr;
  dde_mode_t                cfg_mode;
  dde_mode_t                run_mode;
  dde_tag_t                 tag0;
  logic [TWID_ADDR_W-1:0]   phase0;
  logic                     adv;
  logic                     drain_done;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  logic [IDX_W-1:0]         rd_addr;
  logic [2*SAMPLE_BITS-1:0] rdata;
  logic signed [OUT_W-1:0]  res_re, res_im;
  logic [INDEX_W-1:0]       res_index;

  assign pready  = 1'b1;
  assign reg_sel = dde_reg_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r  <= 1'b0;
      log2_r <= LOG2_W'(LOG2_RESET);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_INVERSE: inv_r  <= pwdata[0];
        REG_LOG2:    log2_r <= pwdata[LOG2_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_INVERSE: prdata = CFG_DATA_W'(inv_r);
      REG_LOG2:    prdata = CFG_DATA_W'(log2_r);
    endcase
  end

  assign cfg_mode.inv   = inv_r;
  assign cfg_mode.log2n = log2_r;

  dde_ram #(
    .WIDTH (2 * SAMPLE_BITS),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_tdata[2*SAMPLE_BITS-1:0]),
    .re    (adv),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  dde_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .cfg_mode   (cfg_mode),
    .adv        (adv),
    .drain_done (drain_done),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr),
    .tag0       (tag0),
    .phase0     (phase0),
    .run_mode   (run_mode)
  );

  dde_mac #(
    .MAX_POINTS  (MAX_POINTS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .tag0       (tag0),
    .phase0     (phase0),
    .rdata      (rdata),
    .run_mode   (run_mode),
    .out_ready  (out_tready),
    .adv        (adv),
    .drain_done (drain_done),
    .out_valid  (out_tvalid),
    .out_re     (res_re),
    .out_im     (res_im),
    .out_index  (res_index),
    .out_last   (out_tlast)
  );

  assign out_tdata = OUT_DATA_W'({res_index, res_im, res_re});

endmodule

### tb/dft_check_pkg.sv
// expected-result predictor and result checker for the direct dft engine testbench
// holds its own cosine table, sample store and mode; depends on dde_pkg for the register codes
package dft_check_pkg;
  import dde_pkg::*;

  // cos(2*pi*m/64) in q1.15, rounded, top entry clipped to 32767
  localparam int COS_Q15 [64] = '{
     32767,  32610,  32138,  31357,  30274,  28899,  27246,  25330,
     23170,  20788,  18205,  15447,  12540,   9512,   6393,   3212,
         0,  -3212,  -6393,  -9512, -12540, -15447, -18205, -20788,
    -23170, -25330, -27246, -28899, -30274, -31357, -32138, -32610,
    -32768, -32610, -32138, -31357, -30274, -28899, -27246, -25330,
    -23170, -20788, -18205, -15447, -12540,  -9512,  -6393,  -3212,
         0,   3212,   6393,   9512,  12540,  15447,  18205,  20788,
     23170,  25330,  27246,  28899,  30274,  31357,  32138,  32610
  };

  typedef struct {
    logic signed [23:0] re;
    logic signed [23:0] im;
    logic [5:0]         idx;
    logic               last;
  } dft_bin_t;

  class dft_bin_predictor;
    bit                 inv;
    bit [2:0]           log2;
    logic signed [15:0] st_re [64];
    logic signed [15:0] st_im [64];
    int unsigned        count;
    dft_bin_t           pending_bins [$];
    int unsigned        errors;

    function new();
      inv = 1'b0;
      log2 = 3'd6;
      count = 0;
      errors = 0;
    endfunction

    function void set_reg(dde_reg_t r, logic [31:0] v);
      if (r == REG_INVERSE) inv = v[0];
      else log2 = v[2:0];
    endfunction

    // round half up after the shift, then clip to 24 bits
    function logic signed [23:0] scale_clip(longint acc, int unsigned sh);
      longint r;
      r = (acc + (longint'(1) <<< (sh - 1))) >>> sh;
      if (r > 8388607) r = 8388607;
      if (r < -8388608) r = -8388608;
      return r[23:0];
    endfunction

    // store one sample; a completed block queues all of its output bins
    function void load_sample(logic signed [15:0] re, logic signed [15:0] im);
      int unsigned l, npts, stride, sh, m;
      longint acc_re, acc_im, a, b, c, s;
      dft_bin_t bin;
      l = log2;
      if (l < 1) l = 1;
      if (l > 6) l = 6;
      npts = 1 << l;
      stride = 64 >> l;
      sh = inv ? 15 + l : 15;
      if (count < 64) begin
        st_re[count] = re;
        st_im[count] = im;
      end
      count = (count + 1) & 127;
      if (count < npts) return;
      count = 0;
      for (int unsigned k = 0; k < npts; k++) begin
        acc_re = 0;
        acc_im = 0;
        for (int unsigned n = 0; n < npts; n++) begin
          m = (((k * n) & (npts - 1)) * stride) & 63;
          c = COS_Q15[m];
          s = COS_Q15[(m + 48) & 63];
          a = st_re[n];
          b = st_im[n];
          if (inv) begin
            acc_re += a * c - b * s;
            acc_im += b * c + a * s;
          end else begin
            acc_re += a * c + b * s;
            acc_im += b * c - a * s;
          end
        end
        bin.re = scale_clip(acc_re, sh);
        bin.im = scale_clip(acc_im, sh);
        bin.idx = k[5:0];
        bin.last = (k == npts - 1);
        pending_bins = {pending_bins, bin};
      end
    endfunction

    function void report(string field, int idx, longint want, longint got);
      $display("%0t: bin %0d %s mismatch, expected %0d actual %0d",
               $time, idx, field, want, got);
      errors++;
    endfunction

    function void check_bin(logic signed [23:0] re, logic signed [23:0] im,
                            logic [5:0] idx, logic last);
      dft_bin_t want;
      if (pending_bins.size() == 0) begin
        $display("%0t: unexpected result, expected none actual index %0d", $time, idx);
        errors++;
        return;
      end
      want = pending_bins.pop_front();
      if (re !== want.re) report("re", want.idx, want.re, re);
      if (im !== want.im) report("im", want.idx, want.im, im);
      if (idx !== want.idx) report("index", want.idx, want.idx, idx);
      if (last !== want.last) report("last", want.idx, want.last, last);
    endfunction
  endclass

endpackage

### tb/tb.sv
// top-level testbench for direct_dft_engine: directed and random sample blocks under
// random stalls on both streams, with results checked against dft_check_pkg
// depends on dde_pkg, dft_check_pkg and the engine rtl
module tb;
  import dde_pkg::*;
  import dft_check_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 200;
  localparam int ITEM_TARGET   = 400;
  localparam int HOLD_CYCLES   = 800;

  typedef enum {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_MOSTLY} ready_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // sample_re, sample_im
  logic [31:0]           in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  // out_re, out_im, out_index
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  dft_bin_predictor dft_pred;
  int unsigned      burst_left = 0;
  int unsigned      sent_items = 0;
  int unsigned      cycles = 0;
  bit               hold_req = 0;

  direct_dft_engine u_top (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      dft_pred.check_bin(out_tdata[23:0], out_tdata[47:24], out_tdata[53:48], out_tlast);
  end

  // receiver: its own ready pattern plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned pattern_left;
    ready_mode_t pattern;
    out_tready <= 1'b0;
    hold_left = 0;
    pattern_left = 0;
    pattern = RDY_ALWAYS;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_left = HOLD_CYCLES;
      end
      if (pattern_left == 0) begin
        pattern = ready_mode_t'($urandom_range(0, 3));
        pattern_left = $urandom_range(20, 200);
      end
      pattern_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (pattern)
          RDY_ALWAYS: out_tready <= 1'b1;
          RDY_HALF:   out_tready <= 1'($urandom_range(0, 1));
          RDY_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
          default:    out_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic write_reg(dde_reg_t r, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(4 * int'(r));
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    dft_pred.set_reg(r, v);
    @(posedge clk);
  endtask

  task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {im, re};
    do @(posedge clk); while (!in_tready);
    burst_left--;
    sent_items++;
    dft_pred.load_sample(re, im);
  endtask

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      1: return 16'($urandom_range(0, 16)) - 16'd8;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_run(int unsigned n_items, bit real_only);
    for (int unsigned i = 0; i < n_items; i++)
      send_sample(pick_value(), real_only ? 16'sd0 : pick_value());
  endtask

  // wait until every queued bin has come out, then let the engine go quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (dft_pred.pending_bins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned sel, lg, npts, blocks;
    logic [31:0] rnd;
    bit real_only;
    dft_pred = new();
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // two-point forward with full-scale corners
    write_reg(REG_LOG2, 32'd1);
    write_reg(REG_INVERSE, 32'd0);
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh8000, 16'sh8000);
    settle();

    // four-point inverse
    write_reg(REG_INVERSE, 32'd1);
    write_reg(REG_LOG2, 32'd2);
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 16'sh0000);
    send_sample(16'sh0000, 16'sh8000);
    send_sample(16'sh0001, 16'shffff);
    settle();

    // length below range clamps to two points
    write_reg(REG_LOG2, 32'd0);
    send_sample(16'sd12345, 16'shffff);
    send_sample(16'shffff, 16'sd12345);
    settle();

    // length above range, then lowered mid-block below the count already loaded
    write_reg(REG_INVERSE, 32'd0);
    write_reg(REG_LOG2, 32'd7);
    send_run(10, 1'b0);
    settle();
    write_reg(REG_LOG2, 32'd3);
    send_sample(16'sh1234, 16'shedcb);
    settle();

    // long output hold-off while the sender keeps offering blocks
    write_reg(REG_INVERSE, 32'd0);
    write_reg(REG_LOG2, 32'd3);
    hold_req = 1;
    burst_left = 1000;
    send_run(32, 1'b0);
    settle();

    // one full-size inverse block reached through the clamp
    write_reg(REG_INVERSE, 32'd1);
    write_reg(REG_LOG2, 32'd7);
    send_run(64, 1'b0);
    settle();

    while (sent_items < ITEM_TARGET) begin
      sel = $urandom_range(0, 19);
      if (sel < 15) lg = $urandom_range(1, 4);
      else if (sel < 17) lg = 5;
      else if (sel == 17) lg = 6;
      else if (sel == 18) lg = 0;
      else lg = 7;
      rnd = $urandom();
      rnd[0] = 1'($urandom_range(0, 1));
      write_reg(REG_INVERSE, rnd);
      rnd = $urandom();
      rnd[2:0] = lg[2:0];
      write_reg(REG_LOG2, rnd);
      npts = 1 << ((lg == 0) ? 1 : (lg == 7) ? 6 : lg);
      blocks = (npts >= 32) ? 1 : $urandom_range(1, 4);
      real_only = ($urandom_range(0, 3) == 0);
      send_run(blocks * npts, real_only);
      // occasionally leave a partial block behind for the next setting
      if ($urandom_range(0, 5) == 0) send_run($urandom_range(1, npts - 1), real_only);
      settle();
    end

    in_tvalid <= 1'b0;
    while (dft_pred.pending_bins.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (dft_pred.errors == 0 && dft_pred.pending_bins.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
